@@ rtl/core/riot_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riot_pkg
// Shared types and constants for the RAM, I/O port and interval timer block.
// ----------------------------------------------------------------------------
package riot_pkg;

  localparam int unsigned RamDepthDef = 128;
  localparam int unsigned DataW       = 8;
  localparam int unsigned AddrW       = 7;
  localparam int unsigned CycW        = 10;

  // I/O register codes (low three address bits)
  localparam logic [2:0] IoPortA     = 3'd0;
  localparam logic [2:0] IoPortB     = 3'd2;
  localparam logic [2:0] IoTimer     = 3'd4;
  localparam logic [2:0] IoFlags     = 3'd5;
  localparam logic [2:0] IoTimerBase = 3'd4;
  localparam logic [2:0] IoPsOffset  = 3'd3;

  // Prescale choice; none until the first timer write
  typedef enum logic [2:0] {
    PsNone = 3'd0,
    Ps1    = 3'd1,
    Ps8    = 3'd2,
    Ps64   = 3'd3,
    Ps1024 = 3'd4
  } psel_e;

  // One bus access as held in the input register
  typedef struct packed {
    logic             wr;
    logic             is_ram;
    logic [2:0]       reg_sel;
    logic [DataW-1:0] wdata;
    logic [DataW-1:0] sw;
    logic [DataW-1:0] bw;
    logic [DataW-1:0] dif;
  } item_t;

  // Request from the pipeline to the I/O and timer unit
  typedef struct packed {
    logic  fire;
    item_t item;
  } io_req_t;

endpackage

@@ rtl/core/riot_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riot_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module riot_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/riot_io.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riot_io
// Switch port reads, timer and flag registers, and the per-access timer step.
// ----------------------------------------------------------------------------
module riot_io (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  riot_pkg::io_req_t       req_i,
  output logic [riot_pkg::DataW-1:0] rdata_o
);
  import riot_pkg::*;

  logic [DataW-1:0] cnt_q, cnt_d;
  logic             fast_q, fast_d;
  logic [1:0]       flags_q, flags_d;
  psel_e            psel_q, psel_d;
  logic [CycW-1:0]  cyc_q, cyc_d;
  logic [CycW-1:0]  mask;
  logic             ps_on;
  logic             due;
  logic [DataW-1:0] rdata;

  always_comb begin
    cnt_d   = cnt_q;
    fast_d  = fast_q;
    flags_d = flags_q;
    psel_d  = psel_q;
    cyc_d   = cyc_q;
    rdata   = '0;
    mask    = '0;
    ps_on   = 1'b0;
    due     = 1'b0;
    if (req_i.fire) begin
      if (!req_i.item.is_ram) begin
        if (req_i.item.wr) begin
          if (req_i.item.reg_sel >= IoTimerBase) begin
            psel_d     = psel_e'(req_i.item.reg_sel - IoPsOffset);
            flags_d[1] = 1'b0;
            fast_d     = (req_i.item.wdata == '0);
            cnt_d      = req_i.item.wdata - 8'd1;
          end
        end else begin
          case (req_i.item.reg_sel)
            IoPortA: rdata = ~{req_i.item.sw[3:0], 4'h0};
            IoPortB: rdata = {5'b0, req_i.item.sw[7:5] ^ 3'b011}
                             | req_i.item.bw | req_i.item.dif;
            IoTimer: begin
              rdata  = cnt_q;
              fast_d = 1'b0;
            end
            IoFlags: begin
              rdata      = {flags_q, 6'b0};
              flags_d[0] = 1'b0;
            end
            default: rdata = '0;
          endcase
        end
      end
      // timer step after the access
      cyc_d = cyc_q + 10'd1;
      unique case (psel_d)
        Ps1:    begin mask = 10'd0;    ps_on = 1'b1; end
        Ps8:    begin mask = 10'd7;    ps_on = 1'b1; end
        Ps64:   begin mask = 10'd63;   ps_on = 1'b1; end
        Ps1024: begin mask = 10'd1023; ps_on = 1'b1; end
        default: begin mask = '0; ps_on = 1'b0; end
      endcase
      due = fast_d || (ps_on && ((cyc_d & mask) == '0));
      if (due) begin
        if (cnt_d == '0) begin
          fast_d  = 1'b1;
          flags_d = 2'b11;
        end
        cnt_d = cnt_d - 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      fast_q  <= 1'b0;
      flags_q <= '0;
      psel_q  <= PsNone;
      cyc_q   <= '0;
    end else begin
      cnt_q   <= cnt_d;
      fast_q  <= fast_d;
      flags_q <= flags_d;
      psel_q  <= psel_d;
      cyc_q   <= cyc_d;
    end
  end

  assign rdata_o = rdata;

endmodule

@@ rtl/core/riot_ram_timer_ports.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riot_ram_timer_ports
// RAM, switch ports and interval timer of a 6532-style bus peripheral.
// ----------------------------------------------------------------------------
// Usage:
//   Each input item is one bus access (read or write, RAM or I/O space).
//   Every accepted item yields exactly one result item carrying read_data_o;
//   writes and unmapped I/O reads return zero. The timer steps once per item.
//   Path: an accepted item enters the input register and moves on into the
//   result register when that register is free, where its result shows on
//   the output (the RAM read is launched at acceptance and its registered
//   data meets the item in the input stage).
//   Throughput: one item per cycle, sustained while out_ready_i is high, set
//   by the single-port RAM which serves one access per clock.
//   Stall: when out_ready_i is low a full result register holds, the input
//   register still fills once, and in_ready_o drops only when both are full.
//   Reset: clears timer, flags, prescale choice, step counter and pipeline
//   valids at once; RAM content reads as zero via per-entry valid bits until
//   an entry is written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module riot_ram_timer_ports #(
  parameter int unsigned RAM_DEPTH = riot_pkg::RamDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        mode_i,
  input  logic                        ram_select_i,
  input  logic [riot_pkg::AddrW-1:0]  address_i,
  input  logic [riot_pkg::DataW-1:0]  write_data_i,
  input  logic [riot_pkg::DataW-1:0]  switch_state_i,
  input  logic [riot_pkg::DataW-1:0]  bw_bits_i,
  input  logic [riot_pkg::DataW-1:0]  difficulty_bits_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [riot_pkg::DataW-1:0]  read_data_o
);
  import riot_pkg::*;

  localparam int unsigned IdxW   = $clog2(RAM_DEPTH);
  localparam logic [8:0]  DepthW = 9'(RAM_DEPTH);

  logic             in_fire;
  logic             s1_fire;
  logic             out_free;
  logic             s1_vld_q;
  item_t            s1_q;
  logic             out_vld_q;
  logic [DataW-1:0] out_data_q;
  logic [DataW-1:0] result;

  logic [8:0]           idx_work;
  logic [IdxW-1:0]      ram_idx;
  logic                 ram_en;
  logic                 ram_we;
  logic [DataW-1:0]     ram_rdata;
  logic [RAM_DEPTH-1:0] ram_vld_q;
  logic                 rd_vld_q;

  io_req_t          io_req;
  logic [DataW-1:0] io_rdata;

  // Handshake: the input stage moves on when the result register is free
  assign out_free   = !out_vld_q || out_ready_i;
  assign s1_fire    = s1_vld_q && out_free;
  assign in_ready_o = !s1_vld_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // Fold the address into the RAM depth: at most eight subtractions
  always_comb begin
    idx_work = {2'b00, address_i};
    for (int i = 0; i < 8; i++) begin
      if (idx_work >= DepthW) begin
        idx_work = idx_work - DepthW;
      end
    end
  end
  assign ram_idx = idx_work[IdxW-1:0];

  // Access the RAM at acceptance; read data waits in the RAM output register
  assign ram_en = in_fire && ram_select_i;
  assign ram_we = mode_i;

  riot_ram #(
    .Width (DataW),
    .Depth (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_idx),
    .wdata_i (write_data_i),
    .rdata_o (ram_rdata)
  );

  // Per-entry written flags stand in for the reset clear of the RAM
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_vld_q <= '0;
    end else if (ram_en && ram_we) begin
      ram_vld_q[ram_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_vld_q <= ram_vld_q[ram_idx];
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_fire) begin
      s1_vld_q <= 1'b1;
    end else if (s1_fire) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q.wr      <= mode_i;
      s1_q.is_ram  <= ram_select_i;
      s1_q.reg_sel <= address_i[2:0];
      s1_q.wdata   <= write_data_i;
      s1_q.sw      <= switch_state_i;
      s1_q.bw      <= bw_bits_i;
      s1_q.dif     <= difficulty_bits_i;
    end
  end

  // I/O and timer: state advances as the item leaves the input register
  assign io_req.fire = s1_fire;
  assign io_req.item = s1_q;

  riot_io u_io (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (io_req),
    .rdata_o (io_rdata)
  );

  // Pick the result byte; writes read back zero
  always_comb begin
    if (s1_q.wr) begin
      result = '0;
    end else if (s1_q.is_ram) begin
      result = rd_vld_q ? ram_rdata : '0;
    end else begin
      result = io_rdata;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_vld_q;
  assign read_data_o = out_data_q;

`ifndef SYNTHESIS
  // A RAM write marks its entry as written
  a_ram_vld_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_en && ram_we) |=> ram_vld_q[$past(ram_idx)])
    else $error("RAM write did not mark its entry");

  // Both stages full and stalled: no new item may enter
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_vld_q && !out_ready_i) |-> !in_ready_o)
    else $error("item accepted while pipeline full");

  // An item leaving the input stage lands in the result register
  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> out_vld_q)
    else $error("result register missed an item");
`endif

endmodule
